// File: rtl/pit3_pkg.sv
package pit3_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 16;

    localparam int TOL_WIDTH = 32;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd4295;
    localparam int TOL_SHIFT = 4 * COORD_FRAC_BITS - 32;

    // difference, product and cross product widths
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    // cross products are split into limbs for the dot product multipliers
    localparam int LIMB = 32;
    localparam int NL   = (XW + LIMB - 1) / LIMB;
    localparam int LPW  = 2 * (LIMB + 1);

    // accumulator width: holds the dot sum plus the scaled tolerance
    localparam int SW_DOT = 2 * XW + 2;
    localparam int SW_TOL = TOL_WIDTH + TOL_SHIFT + 2;
    localparam int SW     = (SW_DOT > SW_TOL) ? SW_DOT : SW_TOL;

    localparam int NS = 7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        logic [NS-1:0] en;
    } pipe_ctl_t;

endpackage

// File: rtl/point_in_triangle_3d_core.sv
// Same-side point-in-triangle test on signed Q16.16 coordinates. One item can be
// accepted every cycle while s_ready is high. Each item passes the seven-stage
// arithmetic pipeline (edge vectors, cross product multiplies, cross subtract,
// limb-split dot product multiplies, two accumulation stages, threshold compare).
// The first stage captures the item and the last stage is the output register.
// A stall on the result side holds the output register and every full stage
// that has no empty stage between it and the output, while the other stages
// keep moving into the gaps, so no item is lost or repeated. The tolerance
// register may only be written while no item is in flight.
module point_in_triangle_3d_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [pit3_pkg::TOL_WIDTH-1:0]  cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  pit3_pkg::coord_t                s_query_x,
    input  pit3_pkg::coord_t                s_query_y,
    input  pit3_pkg::coord_t                s_query_z,
    input  pit3_pkg::coord_t                s_vert_a_x,
    input  pit3_pkg::coord_t                s_vert_a_y,
    input  pit3_pkg::coord_t                s_vert_a_z,
    input  pit3_pkg::coord_t                s_vert_b_x,
    input  pit3_pkg::coord_t                s_vert_b_y,
    input  pit3_pkg::coord_t                s_vert_b_z,
    input  pit3_pkg::coord_t                s_vert_c_x,
    input  pit3_pkg::coord_t                s_vert_c_y,
    input  pit3_pkg::coord_t                s_vert_c_z,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_inside_res,
    output logic                            m_side_ok_bc,
    output logic                            m_side_ok_ca,
    output logic                            m_side_ok_ab
);

    localparam int NS = pit3_pkg::NS;

    logic [pit3_pkg::TOL_WIDTH-1:0] tol_reg;
    logic [pit3_pkg::TOL_WIDTH-1:0] tol_next;
    logic [NS-1:0]                  vld_reg;
    logic [NS-1:0]                  vld_next;
    pit3_pkg::pipe_ctl_t            ctl;

    pit3_pkg::vec3_t pt_p;
    pit3_pkg::vec3_t pt_a;
    pit3_pkg::vec3_t pt_b;
    pit3_pkg::vec3_t pt_c;

    logic ok_bc;
    logic ok_ca;
    logic ok_ab;

    assign pt_p = '{x: s_query_x,  y: s_query_y,  z: s_query_z};
    assign pt_a = '{x: s_vert_a_x, y: s_vert_a_y, z: s_vert_a_z};
    assign pt_b = '{x: s_vert_b_x, y: s_vert_b_y, z: s_vert_b_z};
    assign pt_c = '{x: s_vert_c_x, y: s_vert_c_y, z: s_vert_c_z};

    // a stage loads when it is empty or its content moves on
    always_comb begin
        ctl.en[NS-1] = ~vld_reg[NS-1] | m_ready;
        for (int n = NS - 2; n >= 0; n--) begin
            ctl.en[n] = ~vld_reg[n] | ctl.en[n+1];
        end
    end

    always_comb begin
        vld_next[0] = ctl.en[0] ? s_valid : vld_reg[0];
        for (int n = 1; n < NS; n++) begin
            vld_next[n] = ctl.en[n] ? vld_reg[n-1] : vld_reg[n];
        end
    end

    assign tol_next = cfg_wr_en ? cfg_wr_data : tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            tol_reg <= pit3_pkg::TOL_RESET;
        end else begin
            vld_reg <= vld_next;
            tol_reg <= tol_next;
        end
    end

    pit3_edge u_edge_bc (
        .aclk (aclk),
        .ctl  (ctl),
        .pt_p (pt_p),
        .pt_s (pt_b),
        .pt_e (pt_c),
        .pt_o (pt_a),
        .tol  (tol_reg),
        .ok   (ok_bc)
    );

    pit3_edge u_edge_ca (
        .aclk (aclk),
        .ctl  (ctl),
        .pt_p (pt_p),
        .pt_s (pt_c),
        .pt_e (pt_a),
        .pt_o (pt_b),
        .tol  (tol_reg),
        .ok   (ok_ca)
    );

    pit3_edge u_edge_ab (
        .aclk (aclk),
        .ctl  (ctl),
        .pt_p (pt_p),
        .pt_s (pt_a),
        .pt_e (pt_b),
        .pt_o (pt_c),
        .tol  (tol_reg),
        .ok   (ok_ab)
    );

    assign s_ready      = ctl.en[0];
    assign m_valid      = vld_reg[NS-1];
    assign m_side_ok_bc = ok_bc;
    assign m_side_ok_ca = ok_ca;
    assign m_side_ok_ab = ok_ab;
    assign m_inside_res = ok_bc & ok_ca & ok_ab;

endmodule

// File: rtl/pit3_edge.sv
module pit3_edge (
    input  logic                            aclk,
    input  pit3_pkg::pipe_ctl_t             ctl,
    input  pit3_pkg::vec3_t                 pt_p,
    input  pit3_pkg::vec3_t                 pt_s,
    input  pit3_pkg::vec3_t                 pt_e,
    input  pit3_pkg::vec3_t                 pt_o,
    input  logic [pit3_pkg::TOL_WIDTH-1:0]  tol,
    output logic                            ok
);

    localparam int DW   = pit3_pkg::DW;
    localparam int PW   = pit3_pkg::PW;
    localparam int XW   = pit3_pkg::XW;
    localparam int LIMB = pit3_pkg::LIMB;
    localparam int NL   = pit3_pkg::NL;
    localparam int LPW  = pit3_pkg::LPW;
    localparam int SW   = pit3_pkg::SW;

    pit3_pkg::coord_t p_c [3];
    pit3_pkg::coord_t s_c [3];
    pit3_pkg::coord_t e_c [3];
    pit3_pkg::coord_t o_c [3];

    assign p_c[0] = pt_p.x;
    assign p_c[1] = pt_p.y;
    assign p_c[2] = pt_p.z;
    assign s_c[0] = pt_s.x;
    assign s_c[1] = pt_s.y;
    assign s_c[2] = pt_s.z;
    assign e_c[0] = pt_e.x;
    assign e_c[1] = pt_e.y;
    assign e_c[2] = pt_e.z;
    assign o_c[0] = pt_o.x;
    assign o_c[1] = pt_o.y;
    assign o_c[2] = pt_o.z;

    // stage 1: edge and point vectors
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] w_next [3];

    // stage 2: cross product terms
    logic signed [PW-1:0] mua_reg [3];
    logic signed [PW-1:0] mub_reg [3];
    logic signed [PW-1:0] mwa_reg [3];
    logic signed [PW-1:0] mwb_reg [3];
    logic signed [PW-1:0] mua_next [3];
    logic signed [PW-1:0] mub_next [3];
    logic signed [PW-1:0] mwa_next [3];
    logic signed [PW-1:0] mwb_next [3];

    // stage 3: cross products
    logic signed [XW-1:0] cu_reg [3];
    logic signed [XW-1:0] cw_reg [3];
    logic signed [XW-1:0] cu_next [3];
    logic signed [XW-1:0] cw_next [3];

    // stage 4: limb partial products
    logic signed [LIMB:0]  cu_l [3][NL];
    logic signed [LIMB:0]  cw_l [3][NL];
    logic signed [LPW-1:0] pp_reg  [3][NL][NL];
    logic signed [LPW-1:0] pp_next [3][NL][NL];

    // stage 5: row sums, stage 6: dot sums, stage 7: sign test
    logic signed [SW-1:0] row_reg  [3][NL];
    logic signed [SW-1:0] row_next [3][NL];
    logic signed [SW-1:0] dot_reg  [3];
    logic signed [SW-1:0] dot_next [3];
    logic signed [SW-1:0] thr;
    logic signed [SW-1:0] total;
    logic                 ok_reg;
    logic                 ok_next;

    genvar k, i, j;

    generate
        for (k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;

            assign d_next[k] = DW'(e_c[k]) - DW'(s_c[k]);
            assign u_next[k] = DW'(p_c[k]) - DW'(s_c[k]);
            assign w_next[k] = DW'(o_c[k]) - DW'(s_c[k]);

            assign mua_next[k] = PW'(d_reg[K1]) * PW'(u_reg[K2]);
            assign mub_next[k] = PW'(d_reg[K2]) * PW'(u_reg[K1]);
            assign mwa_next[k] = PW'(d_reg[K1]) * PW'(w_reg[K2]);
            assign mwb_next[k] = PW'(d_reg[K2]) * PW'(w_reg[K1]);

            assign cu_next[k] = XW'(mua_reg[k]) - XW'(mub_reg[k]);
            assign cw_next[k] = XW'(mwa_reg[k]) - XW'(mwb_reg[k]);

            for (i = 0; i < NL; i++) begin : g_limb
                if (i < NL - 1) begin : g_low
                    assign cu_l[k][i] = {1'b0, cu_reg[k][LIMB*i +: LIMB]};
                    assign cw_l[k][i] = {1'b0, cw_reg[k][LIMB*i +: LIMB]};
                end else begin : g_top
                    assign cu_l[k][i] = (LIMB+1)'($signed(cu_reg[k][XW-1:LIMB*i]));
                    assign cw_l[k][i] = (LIMB+1)'($signed(cw_reg[k][XW-1:LIMB*i]));
                end
            end

            for (i = 0; i < NL; i++) begin : g_pp_row
                for (j = 0; j < NL; j++) begin : g_pp_col
                    assign pp_next[k][i][j] = LPW'(cu_l[k][i]) * LPW'(cw_l[k][j]);
                end

                always_comb begin
                    logic signed [SW-1:0] acc;
                    acc = '0;
                    for (int n = 0; n < NL; n++) begin
                        acc = acc + (SW'(pp_reg[k][i][n]) <<< (LIMB * n));
                    end
                    row_next[k][i] = acc;
                end
            end

            always_comb begin
                logic signed [SW-1:0] acc;
                acc = '0;
                for (int n = 0; n < NL; n++) begin
                    acc = acc + (row_reg[k][n] <<< (LIMB * n));
                end
                dot_next[k] = acc;
            end
        end
    endgenerate

    // edge passes when dot + tol * 2^(4F-32) >= 0
    assign thr     = $signed(SW'(tol) << pit3_pkg::TOL_SHIFT);
    assign total   = dot_reg[0] + dot_reg[1] + dot_reg[2] + thr;
    assign ok_next = ~total[SW-1];

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            d_reg <= d_next;
            u_reg <= u_next;
            w_reg <= w_next;
        end
        if (ctl.en[1]) begin
            mua_reg <= mua_next;
            mub_reg <= mub_next;
            mwa_reg <= mwa_next;
            mwb_reg <= mwb_next;
        end
        if (ctl.en[2]) begin
            cu_reg <= cu_next;
            cw_reg <= cw_next;
        end
        if (ctl.en[3]) begin
            pp_reg <= pp_next;
        end
        if (ctl.en[4]) begin
            row_reg <= row_next;
        end
        if (ctl.en[5]) begin
            dot_reg <= dot_next;
        end
        if (ctl.en[6]) begin
            ok_reg <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule
